FILE: src/frt_pkg.sv
package frt_pkg;

  localparam int Slots = 4;
  localparam int BufBytes = 1280;
  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int DataDepth = Slots * BufBytes;
  localparam int DataAw = $clog2(DataDepth);

  localparam logic [4:0] DISP_FIRST = 5'b11000;
  localparam logic [4:0] DISP_NEXT  = 5'b11100;
  localparam logic [10:0] POS_MAX = 11'h7FF;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PENDING = 3'd1;
  localparam logic [2:0] ST_ERROR   = 3'd2;
  localparam logic [2:0] ST_NOMEM   = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [15:0] size_word;
    logic [15:0] frag_tag;
    logic [7:0]  frag_offset;
    logic [63:0] src_addr;
    logic [1:0]  src_mode;
    logic [63:0] dst_addr;
    logic [1:0]  dst_mode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  read_slot;
    logic [10:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [10:0] received_octets;
    logic [7:0]  read_data;
  } out_item_t;

  // Per-slot descriptor kept in registers
  typedef struct packed {
    logic        busy;
    logic [63:0] src;
    logic [1:0]  smode;
    logic [63:0] dst;
    logic [1:0]  dmode;
    logic [10:0] size;
    logic [15:0] tag;
    logic [10:0] count;
  } slot_desc_t;

endpackage

FILE: src/frt_ram.sv
module frt_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/fragment_reassembly_table.sv
// Fragment reassembly table. Payload bytes of fragmented datagrams arrive
// one per transfer on the input channel, each carrying the fragment header;
// the header is taken on the first byte of a fragment. A first fragment
// claims the lowest free slot, a subsequent fragment joins the highest busy
// slot matching addresses, modes, size and tag. Bytes go to a buffer memory
// (Slots x BufBytes bytes) at offset*8 plus position. The final byte of a
// fragment yields one status result; a read request yields one byte of a
// slot buffer. A fragment byte is accepted, and the slot descriptors and the
// memory write are updated at that edge; a final byte's result sits in the
// output register from the next cycle. For a read request the input holds
// off while the registered memory read returns. The input also holds off
// while a result waits in the output register with out_ready low. Slots are
// free after reset; buffer contents are undefined until written.
module fragment_reassembly_table
  import frt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  slot_desc_t desc [Slots];
  logic             in_fragment;
  logic [SlotW-1:0] cur_slot;
  logic [10:0]      cur_pos;
  logic [2:0]       cur_status;

  // state held while a read waits for its memory data
  logic        rd_pend;
  out_item_t   rd_item;
  logic        rd_zero;

  logic        acc;
  logic        out_load;
  out_item_t   out_next;

  // header decode
  logic [4:0]  disp;
  logic [10:0] hsize;
  logic        free_found, match_found;
  logic [SlotW-1:0] free_idx, match_idx;

  // effective fragment context for this byte
  logic             e_ok;
  logic [SlotW-1:0] e_slot;
  logic [10:0]      e_pos;
  logic [2:0]       e_status;
  logic [10:0]      e_count;
  logic [10:0]      e_size;
  logic             claim;
  logic             frag_done;

  logic              ram_we;
  logic [DataAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;

  assign in_ready = !rd_pend && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  assign disp  = in_data.size_word[15:11];
  assign hsize = in_data.size_word[10:0];

  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!desc[i].busy) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
    for (int i = 0; i < Slots; i++) begin
      if (desc[i].busy && desc[i].src == in_data.src_addr &&
          desc[i].smode == in_data.src_mode && desc[i].dst == in_data.dst_addr &&
          desc[i].dmode == in_data.dst_mode && desc[i].size == hsize &&
          desc[i].tag == in_data.frag_tag) begin
        match_found = 1'b1;
        match_idx   = SlotW'(i);
      end
    end
  end

  // Resolve the fragment context: header on a new fragment, registers otherwise
  always_comb begin
    claim    = 1'b0;
    e_slot   = cur_slot;
    e_pos    = cur_pos;
    e_status = cur_status;
    if (!in_fragment) begin
      e_slot = '0;
      e_pos  = '0;
      if (disp == DISP_FIRST) begin
        claim    = free_found;
        e_slot   = free_idx;
        e_status = free_found ? ST_DONE : ST_NOMEM;
      end else if (disp == DISP_NEXT) begin
        e_slot   = match_idx;
        e_status = match_found ? ST_DONE : ST_ERROR;
        if (match_found) begin
          e_pos = {in_data.frag_offset, 3'b000};
        end
      end else begin
        e_status = ST_ERROR;
      end
    end
    e_ok    = (e_status == ST_DONE);
    e_count = (claim ? 11'd0 : desc[e_slot].count) + 11'd1;
    // a freshly claimed slot compares against the size in this header
    e_size  = claim ? hsize : desc[e_slot].size;
  end

  assign frag_done = e_ok && in_data.last_byte && (e_size == e_count);

  assign ram_we    = acc && !in_data.req_type && e_ok && (e_pos < 11'(BufBytes));
  assign ram_waddr = DataAw'(e_slot) * DataAw'(BufBytes) + DataAw'(e_pos);
  assign ram_raddr = DataAw'(in_data.read_slot[SlotW-1:0]) * DataAw'(BufBytes)
                   + DataAw'(in_data.read_addr);

  frt_ram #(.Width(8), .Depth(DataDepth)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: fragment results load on accept, read results when their memory data returns
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (rd_pend) begin
      out_load = 1'b1;
      out_next = rd_item;
      out_next.read_data = rd_zero ? 8'd0 : ram_rdata;
    end else if (acc && !in_data.req_type && in_data.last_byte) begin
      out_load = 1'b1;
      if (e_ok) begin
        out_next.status = frag_done ? ST_DONE : ST_PENDING;
        out_next.slot   = 4'(e_slot);
        out_next.received_octets = e_count;
      end else begin
        out_next.status = (e_status == ST_NOMEM) ? ST_NOMEM : ST_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      in_fragment <= 1'b0;
      cur_slot    <= '0;
      cur_pos     <= '0;
      cur_status  <= ST_DONE;
      for (int i = 0; i < Slots; i++) begin
        desc[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= out_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= acc && in_data.req_type;
      if (acc && in_data.req_type) begin
        rd_item.status <= ST_READ;
        rd_item.slot   <= in_data.read_slot;
        rd_item.received_octets <= (32'(in_data.read_slot) < Slots)
                                 ? desc[in_data.read_slot[SlotW-1:0]].count : 11'd0;
        rd_item.read_data <= '0;
        rd_zero <= !(32'(in_data.read_slot) < Slots) ||
                   !(32'(in_data.read_addr) < BufBytes);
      end
      if (acc && !in_data.req_type) begin
        in_fragment <= !in_data.last_byte;
        cur_slot    <= e_slot;
        cur_status  <= e_status;
        cur_pos     <= (e_ok && e_pos != POS_MAX) ? e_pos + 11'd1 : e_pos;
        if (claim) begin
          desc[e_slot].src   <= in_data.src_addr;
          desc[e_slot].smode <= in_data.src_mode;
          desc[e_slot].dst   <= in_data.dst_addr;
          desc[e_slot].dmode <= in_data.dst_mode;
          desc[e_slot].size  <= hsize;
          desc[e_slot].tag   <= in_data.frag_tag;
        end
        if (e_ok) begin
          desc[e_slot].count <= e_count;
          // take the slot on a claim, free it when a fragment's last byte brings its count to the size
          if (claim || frag_done) begin
            desc[e_slot].busy <= !frag_done;
          end
        end
      end
    end
  end

  // No transfer is taken while a read waits for its memory data
  a_no_acc_rd: assert property (@(posedge clk) disable iff (rst) rd_pend |-> !in_ready)
    else $error("input taken during read");
  // A read result always reaches the output register in the cycle after its read is pending
  a_rd_out: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> (out_valid && out_data.status == ST_READ))
    else $error("read result lost");
  // A held result does not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed under stall");

endmodule
